FILE: hdl/bjt_pkg.sv
package bjt_pkg;

    localparam int MAX_BLOCKS      = 4096;
    localparam int BLOCKS_PER_PART = 16;
    localparam int MIN_BITS        = 16;
    localparam int OFF_W           = 48;
    localparam int LEN_W           = 32;
    localparam int IDX_W           = $clog2(MAX_BLOCKS + 1);
    localparam int PART_BITS       = $clog2(BLOCKS_PER_PART);
    localparam int NUM_PARTS       = MAX_BLOCKS / BLOCKS_PER_PART + 1;
    localparam int PIDX_W          = IDX_W - PART_BITS;
    localparam int CNT_W           = $clog2(BLOCKS_PER_PART + 1);
    localparam int PROD_W          = PART_BITS + MIN_BITS;
    localparam int S_DATA_W        = 48;
    localparam int M_DATA_W        = 56;
    localparam logic [OFF_W-1:0] BASE_RESET = 48'd512;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_FINISH = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_PHASE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLOSE,
        S_LK1,
        S_LK2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    latch;
        logic    append;
        logic    set_ready;
        logic    pass_init;
        logic    pass_step;
        logic    pass_end;
        logic    lk_calc;
        logic    lk_sum;
        logic    set_stat;
        status_t stat;
        logic    emit;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic ready;
        logic full;
        logic idx_bad;
        logic pend_zero;
        logic close_now;
        logic pass_more;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hdl/bjt_ram.sv
module bjt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/bjt_ctrl.sv
module bjt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bjt_pkg::dp_stat_t  st,
    output bjt_pkg::ctrl_cmd_t cmd
);
    import bjt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.stat   = ST_OK;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.set_stat = 1'b1;
                state_next   = S_DONE;
                case (st.cmd)
                    CMD_APPEND: begin
                        if (st.ready) begin
                            cmd.stat = ST_PHASE;
                        end else if (st.full) begin
                            cmd.stat = ST_FULL;
                        end else begin
                            cmd.append = 1'b1;
                            if (st.close_now) begin
                                cmd.pass_init = 1'b1;
                                state_next    = S_CLOSE;
                            end
                        end
                    end
                    CMD_FINISH: begin
                        if (st.ready) begin
                            cmd.stat = ST_PHASE;
                        end else begin
                            cmd.set_ready = 1'b1;
                            if (!st.pend_zero) begin
                                cmd.pass_init = 1'b1;
                                state_next    = S_CLOSE;
                            end
                        end
                    end
                    CMD_LOOKUP: begin
                        if (!st.ready) begin
                            cmd.stat = ST_PHASE;
                        end else if (st.idx_bad) begin
                            cmd.stat = ST_RANGE;
                        end else begin
                            cmd.set_stat = 1'b0;
                            state_next   = S_LK1;
                        end
                    end
                    default: begin
                        cmd.stat = ST_PHASE;
                    end
                endcase
            end
            S_CLOSE: begin
                if (st.pass_more) begin
                    cmd.pass_step = 1'b1;
                end else begin
                    cmd.pass_end = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_LK1: begin
                cmd.lk_calc = 1'b1;
                state_next  = S_LK2;
            end
            S_LK2: begin
                cmd.lk_sum = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/bjt_dp.sv
module bjt_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [bjt_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           cfg_valid,
    input  logic [bjt_pkg::OFF_W-1:0]      cfg_data,
    input  bjt_pkg::ctrl_cmd_t             cmd,
    output bjt_pkg::dp_stat_t              st,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bjt_pkg::M_DATA_W-1:0]   m_tdata
);
    import bjt_pkg::*;

    cmd_t               cmd_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [OFF_W-1:0]   base_reg;
    logic [OFF_W-1:0]   run_off_reg;
    logic [IDX_W-1:0]   loaded_reg;
    logic               ready_reg;
    logic [CNT_W-1:0]   pend_cnt_reg;
    logic [CNT_W-1:0]   pass_cnt_reg;
    logic [MIN_BITS-1:0] min_reg;
    logic [MIN_BITS-1:0] prev_delta_reg;
    logic [PIDX_W-1:0]  open_part_reg;
    logic [MIN_BITS-1:0] pend_buf_reg [BLOCKS_PER_PART];
    logic [PROD_W-1:0]  prod_reg;
    logic [OFF_W-1:0]   sum_a_reg;
    logic [MIN_BITS-1:0] delta_reg;
    logic [OFF_W-1:0]   res_off_reg;
    status_t            res_stat_reg;
    logic [OFF_W-1:0]   out_off_reg;
    status_t            out_stat_reg;
    logic               out_valid_reg;

    logic [IDX_W-1:0]    k;
    logic                k_start;
    logic                k_low;
    logic [OFF_W-1:0]    sum_off;
    logic [MIN_BITS-1:0] len16;
    logic [MIN_BITS-1:0] pass_delta;
    logic                pass_more;
    logic                idx_low;

    logic                delta_we;
    logic [IDX_W-1:0]    delta_waddr;
    logic [MIN_BITS-1:0] delta_wdata;
    logic [MIN_BITS-1:0] delta_q;
    logic                off_we;
    logic [OFF_W-1:0]    off_q;
    logic                min_we;
    logic [MIN_BITS-1:0] min_q;
    logic [MIN_BITS-1:0] lk_min;
    logic [OFF_W-1:0]    lk_off;
    logic [PROD_W:0]     small_sum;

    assign k         = loaded_reg + 1'b1;
    assign k_start   = (k[PART_BITS-1:0] == '0);
    assign k_low     = (k < IDX_W'(BLOCKS_PER_PART));
    assign len16     = len_reg[MIN_BITS-1:0];
    assign sum_off   = run_off_reg + {{(OFF_W-LEN_W){1'b0}}, len_reg};
    assign pass_more = (pass_cnt_reg < pend_cnt_reg);
    assign pass_delta = prev_delta_reg + pend_buf_reg[pass_cnt_reg[PART_BITS-1:0]] - min_reg;
    assign idx_low   = (idx_reg[IDX_W-1:PART_BITS] == '0);

    // the close pass and an append never share a cycle
    always_comb begin
        delta_we    = 1'b0;
        delta_waddr = k;
        delta_wdata = '0;
        if (cmd.pass_step && pass_more) begin
            delta_we    = 1'b1;
            delta_waddr = {open_part_reg, pass_cnt_reg[PART_BITS-1:0]};
            delta_wdata = pass_delta;
        end else if (cmd.append && k_start) begin
            delta_we = 1'b1;
        end else if (cmd.append && k_low) begin
            delta_we    = 1'b1;
            delta_wdata = prev_delta_reg + len16;
        end
    end

    assign off_we = cmd.append && k_start;
    assign min_we = cmd.pass_end;

    bjt_ram #(.WIDTH(MIN_BITS), .DEPTH(MAX_BLOCKS + 1)) u_delta_ram (
        .aclk  (aclk),
        .we    (delta_we),
        .waddr (delta_waddr),
        .wdata (delta_wdata),
        .raddr (idx_reg),
        .rdata (delta_q)
    );

    bjt_ram #(.WIDTH(OFF_W), .DEPTH(NUM_PARTS)) u_off_ram (
        .aclk  (aclk),
        .we    (off_we),
        .waddr (k[IDX_W-1:PART_BITS]),
        .wdata (sum_off),
        .raddr (idx_reg[IDX_W-1:PART_BITS]),
        .rdata (off_q)
    );

    bjt_ram #(.WIDTH(MIN_BITS), .DEPTH(NUM_PARTS)) u_min_ram (
        .aclk  (aclk),
        .we    (min_we),
        .waddr (open_part_reg),
        .wdata (min_reg),
        .raddr (idx_reg[IDX_W-1:PART_BITS]),
        .rdata (min_q)
    );

    // part zero and block zero are never written: offset, minimum and delta are zero
    assign lk_min    = idx_low ? '0 : min_q;
    assign lk_off    = idx_low ? '0 : off_q;
    assign small_sum = {1'b0, prod_reg} + {{(PROD_W+1-MIN_BITS){1'b0}}, delta_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= BASE_RESET;
            run_off_reg    <= '0;
            loaded_reg     <= '0;
            ready_reg      <= 1'b0;
            pend_cnt_reg   <= '0;
            prev_delta_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            if (cmd.append) begin
                run_off_reg <= sum_off;
                loaded_reg  <= k;
                if (k_start) begin
                    pend_cnt_reg <= CNT_W'(1);
                end else if (!k_low) begin
                    pend_cnt_reg <= pend_cnt_reg + 1'b1;
                end
            end
            if (cmd.pass_end) begin
                pend_cnt_reg <= '0;
            end
            if (cmd.pass_init) begin
                prev_delta_reg <= '0;
            end else if (cmd.pass_step && pass_more) begin
                prev_delta_reg <= pass_delta;
            end else if (cmd.append && k_low && !k_start) begin
                prev_delta_reg <= prev_delta_reg + len16;
            end
            if (cmd.set_ready) begin
                ready_reg <= 1'b1;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cmd_reg <= cmd_t'(s_tdata[1:0]);
            len_reg <= s_tdata[LEN_W+1:2];
            idx_reg <= s_tdata[IDX_W+LEN_W+1:LEN_W+2];
        end
        if (cmd.append) begin
            if (k_start) begin
                pend_buf_reg[0] <= len16;
                min_reg         <= len16;
                open_part_reg   <= k[IDX_W-1:PART_BITS];
            end else if (!k_low) begin
                pend_buf_reg[pend_cnt_reg[PART_BITS-1:0]] <= len16;
                if (len16 < min_reg) begin
                    min_reg <= len16;
                end
            end
        end
        if (cmd.pass_init) begin
            pass_cnt_reg <= CNT_W'(1);
        end else if (cmd.pass_step && pass_more) begin
            pass_cnt_reg <= pass_cnt_reg + 1'b1;
        end
        if (cmd.lk_calc) begin
            prod_reg  <= PROD_W'(idx_reg[PART_BITS-1:0]) * PROD_W'(lk_min);
            sum_a_reg <= base_reg + lk_off;
            delta_reg <= (idx_reg == '0) ? '0 : delta_q;
        end
        if (cmd.lk_sum) begin
            res_off_reg  <= sum_a_reg + {{(OFF_W-PROD_W-1){1'b0}}, small_sum};
            res_stat_reg <= ST_OK;
        end
        if (cmd.set_stat) begin
            res_off_reg  <= '0;
            res_stat_reg <= cmd.stat;
        end
        if (cmd.emit) begin
            out_off_reg  <= res_off_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign st.cmd       = cmd_reg;
    assign st.ready     = ready_reg;
    assign st.full      = (loaded_reg == IDX_W'(MAX_BLOCKS));
    assign st.idx_bad   = (idx_reg > loaded_reg);
    assign st.pend_zero = (pend_cnt_reg == '0);
    assign st.close_now = !k_start && !k_low && (pend_cnt_reg == CNT_W'(BLOCKS_PER_PART - 1));
    assign st.pass_more = pass_more;
    assign st.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-OFF_W-2){1'b0}}, out_stat_reg, out_off_reg};

    a_loaded_max: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= IDX_W'(MAX_BLOCKS))
        else $error("block count beyond capacity");

    a_pend_max: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg <= CNT_W'(BLOCKS_PER_PART))
        else $error("pending count beyond part size");

    a_ready_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |=> ready_reg)
        else $error("table ready dropped without reset");

    a_no_append_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |-> !ready_reg)
        else $error("append after finish");

endmodule

FILE: hdl/block_offset_jump_table.sv
// channel  dir  handshake                  payload
// s_       in   s_tvalid / s_tready        command, block_length, block_index
// m_       out  m_tvalid / m_tready        block offset, status
// cfg_     in   cfg_valid / cfg_ready      base_offset (48 bits)
//
// an append or finish is latched, executed and emitted; one that closes a part adds a pass over its
// buffered lengths, one delta ram write a cycle
// a lookup goes through ram read, multiply, final add, result register
// the next request is taken while a result still waits in the output register
// reset is synchronous, active low; the tables need no clearing pass
// cfg_ready is always high
module block_offset_jump_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] command, [33:2] block_length, [46:34] block_index, [47] zero
    input  logic [bjt_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [47:0] block offset, [49:48] status, [55:50] zero
    output logic [bjt_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bjt_pkg::OFF_W-1:0]     cfg_data
);
    import bjt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  st;

    assign cfg_ready = 1'b1;

    bjt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bjt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
